// ----- design/gcr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types and constants of the great-circle radius test core.
// ----------------------------------------------------------------------------
package gcr_pkg;

   typedef struct packed {
      logic signed [31:0] point_lat;
      logic signed [31:0] point_lng;
   } gcr_req_type;

   typedef struct packed {
      logic        inside_res;
      logic [29:0] distance_miles;
   } gcr_rsp_type;

   localparam logic [1:0] CSR_CENTER_LAT   = 2'd0;
   localparam logic [1:0] CSR_CENTER_LNG   = 2'd1;
   localparam logic [1:0] CSR_RADIUS_MILES = 2'd2;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
   localparam logic [31:0]        DIST_SCALE  = 32'd1631904838;
   localparam logic [31:0]        ANGLE_MAX   = 32'h8000_0000;

   function automatic logic [31:0] atan_val(input logic [4:0] idx);
      logic [31:0] t;
      case (idx)
         5'd0: t = 32'h20000000;
         5'd1: t = 32'h12E4051E;
         5'd2: t = 32'h09FB385B;
         5'd3: t = 32'h051111D4;
         5'd4: t = 32'h028B0D43;
         5'd5: t = 32'h0145D7E1;
         5'd6: t = 32'h00A2F61E;
         5'd7: t = 32'h00517C55;
         5'd8: t = 32'h0028BE53;
         5'd9: t = 32'h00145F2F;
         5'd10: t = 32'h000A2F98;
         5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6;
         5'd13: t = 32'h000145F3;
         5'd14: t = 32'h0000A2FA;
         5'd15: t = 32'h0000517D;
         5'd16: t = 32'h000028BE;
         5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A30;
         5'd19: t = 32'h00000518;
         5'd20: t = 32'h0000028C;
         5'd21: t = 32'h00000146;
         5'd22: t = 32'h000000A3;
         5'd23: t = 32'h00000051;
         5'd24: t = 32'h00000029;
         5'd25: t = 32'h00000014;
         5'd26: t = 32'h0000000A;
         5'd27: t = 32'h00000005;
         5'd28: t = 32'h00000003;
         5'd29: t = 32'h00000001;
         5'd30: t = 32'h00000001;
         default: t = 32'h00000000;
      endcase
      return t;
   endfunction

endpackage

// ----- design/gcr_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_fifo
// Short register queue between the front and the back of the core.
// ----------------------------------------------------------------------------
module gcr_fifo #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;

   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? AW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? AW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   no_overflow: assert property (@(posedge clock) disable iff (reset) full |-> !push)
      else $error("Item pushed into a full queue.");
   no_underflow: assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("Item popped from an empty queue.");

endmodule

// ----- design/gcr_sincos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_sincos
// Pipelined rotation CORDIC giving cosine and sine in Q2.30.
// ----------------------------------------------------------------------------
module gcr_sincos #(
   parameter int STAGES = 28
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] angle,
   output logic               out_valid,
   output logic signed [31:0] cos_out,
   output logic signed [31:0] sin_out
);
   import gcr_pkg::*;

   logic signed [33:0] x_ff [0:STAGES];
   logic signed [33:0] y_ff [0:STAGES];
   logic signed [33:0] z_ff [0:STAGES];
   logic               flip_ff [0:STAGES];
   logic [STAGES:0]    vld_ff;
   logic               flip_in;
   logic [31:0]        z0_in;
   logic signed [31:0] cos_ff, sin_ff;
   logic               out_vld_ff;

   assign flip_in = (angle > 32'sd1073741824) || (angle < -32'sd1073741824);
   assign z0_in   = flip_in ? 32'(angle + 32'sh8000_0000) : angle;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      x_ff[0]    <= CORDIC_GAIN;
      y_ff[0]    <= '0;
      z_ff[0]    <= 34'(signed'(z0_in));
      flip_ff[0] <= flip_in;
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic [31:0] ATAN = atan_val(5'(i));
      logic signed [33:0] dx, dy, t;
      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;
      assign t  = signed'({2'b00, ATAN});
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (!z_ff[i][33]) begin
            x_ff[i+1] <= x_ff[i] - dy;
            y_ff[i+1] <= y_ff[i] + dx;
            z_ff[i+1] <= z_ff[i] - t;
         end else begin
            x_ff[i+1] <= x_ff[i] + dy;
            y_ff[i+1] <= y_ff[i] - dx;
            z_ff[i+1] <= z_ff[i] + t;
         end
         flip_ff[i+1] <= flip_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[STAGES];
      end
      cos_ff <= flip_ff[STAGES] ? 32'(-x_ff[STAGES]) : 32'(x_ff[STAGES]);
      sin_ff <= flip_ff[STAGES] ? 32'(-y_ff[STAGES]) : 32'(y_ff[STAGES]);
   end

   assign out_valid = out_vld_ff;
   assign cos_out   = cos_ff;
   assign sin_out   = sin_ff;

endmodule

// ----- design/gcr_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module gcr_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [60:0]        value,
   input  logic signed [31:0] tag_in,
   output logic               out_valid,
   output logic [30:0]        root,
   output logic signed [31:0] tag_out
);
   localparam int STEPS = 31;

   logic [60:0]        rem_ff [0:STEPS];
   logic [61:0]        r_ff   [0:STEPS];
   logic signed [31:0] tag_ff [0:STEPS];
   logic [STEPS:0]     vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      rem_ff[0] <= value;
      r_ff[0]   <= '0;
      tag_ff[0] <= tag_in;
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [61:0] b, trial;
      assign b     = 62'(1) << (60 - 2 * k);
      assign trial = r_ff[k] + b;
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if ({1'b0, rem_ff[k]} >= trial) begin
            rem_ff[k+1] <= 61'({1'b0, rem_ff[k]} - trial);
            r_ff[k+1]   <= (r_ff[k] >> 1) + b;
         end else begin
            rem_ff[k+1] <= rem_ff[k];
            r_ff[k+1]   <= r_ff[k] >> 1;
         end
         tag_ff[k+1] <= tag_ff[k];
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign root      = r_ff[STEPS][30:0];
   assign tag_out   = tag_ff[STEPS];

endmodule

// ----- design/gcr_acos.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_acos
// Pipelined vectoring CORDIC giving the angle of (c, s) in [0, 180] degrees.
// ----------------------------------------------------------------------------
module gcr_acos #(
   parameter int STAGES = 28
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] cos_val,
   input  logic [30:0]        sin_val,
   output logic               out_valid,
   output logic [31:0]        angle
);
   import gcr_pkg::*;

   logic signed [33:0] x_ff [0:STAGES];
   logic signed [33:0] y_ff [0:STAGES];
   logic signed [33:0] z_ff [0:STAGES];
   logic [STAGES:0]    vld_ff;
   logic signed [33:0] c_ext, s_ext;
   logic [31:0]        ang_ff;
   logic               out_vld_ff;

   assign c_ext = 34'(cos_val);
   assign s_ext = signed'({3'b000, sin_val});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      if (c_ext < 0) begin
         x_ff[0] <= s_ext;
         y_ff[0] <= -c_ext;
         z_ff[0] <= ONE_Q30;
      end else begin
         x_ff[0] <= c_ext;
         y_ff[0] <= s_ext;
         z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      localparam logic [31:0] ATAN = atan_val(5'(i));
      logic signed [33:0] dx, dy, t;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      assign t  = signed'({2'b00, ATAN});
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (y_ff[i] > 0) begin
            x_ff[i+1] <= x_ff[i] + dx;
            y_ff[i+1] <= y_ff[i] - dy;
            z_ff[i+1] <= z_ff[i] + t;
         end else begin
            x_ff[i+1] <= x_ff[i] - dx;
            y_ff[i+1] <= y_ff[i] + dy;
            z_ff[i+1] <= z_ff[i] - t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[STAGES];
      end
      if (z_ff[STAGES][33]) begin
         ang_ff <= '0;
      end else if (z_ff[STAGES] > signed'({2'b00, ANGLE_MAX})) begin
         ang_ff <= ANGLE_MAX;
      end else begin
         ang_ff <= z_ff[STAGES][31:0];
      end
   end

   assign out_valid = out_vld_ff;
   assign angle     = ang_ff;

endmodule

// ----- design/great_circle_radius_test_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_radius_test_core
// Geofence test of a point against a circle on the earth by great-circle
// distance.
//
// Channel   Ports                          Handshake
// input     req                            start high and busy low
// result    rsp                            rsp_valid, one cycle, no stall
// config    csr_index, csr_wdata           csr_we
//
// One item is accepted in every cycle while busy is low; busy stays low in normal use.
// An item passes from acceptance to the result through the queue, a sine and
// cosine CORDIC pipeline, the multiply stages, the 31-stage square root
// pipeline, the arccosine CORDIC pipeline and the distance registers.
// Reset is synchronous and clears all valid bits, the queue pointers and the configuration registers.
// The receiver cannot stall, so the back end drains the queue every cycle.
// ----------------------------------------------------------------------------
module great_circle_radius_test_core #(
   parameter int CORDIC_STAGES = 28
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  gcr_pkg::gcr_req_type req,
   output logic                 rsp_valid,
   output gcr_pkg::gcr_rsp_type rsp,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import gcr_pkg::*;

   logic signed [31:0] center_lat_ff, center_lng_ff;
   logic [29:0]        radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_lat_ff <= '0;
         center_lng_ff <= '0;
         radius_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_LAT:   center_lat_ff <= csr_wdata;
            CSR_CENTER_LNG:   center_lng_ff <= csr_wdata;
            CSR_RADIUS_MILES: radius_ff     <= csr_wdata[29:0];
            default: ;
         endcase
      end
   end

   // Front end: accept the point and form the longitude difference.
   logic        accept, q_empty, q_full, pop;
   logic [95:0] push_data, pop_data;

   assign accept    = start && !busy;
   assign push_data = {center_lat_ff, req.point_lat, 32'(req.point_lng - center_lng_ff)};
   assign busy      = q_full;
   assign pop       = !q_empty;

   gcr_fifo #(.WIDTH(96), .DEPTH(4)) u_fifo (
      .clock(clock), .reset(reset),
      .push(accept), .push_data(push_data),
      .pop(pop), .pop_data(pop_data),
      .empty(q_empty), .full(q_full)
   );

   // Back end.
   logic               sc_vld1, sc_vld2, sc_vld3;
   logic signed [31:0] c1, s1, c2, s2, cd, sd;

   gcr_sincos #(.STAGES(CORDIC_STAGES)) u_sc_center (
      .clock(clock), .reset(reset), .in_valid(pop), .angle(pop_data[95:64]),
      .out_valid(sc_vld1), .cos_out(c1), .sin_out(s1)
   );
   gcr_sincos #(.STAGES(CORDIC_STAGES)) u_sc_point (
      .clock(clock), .reset(reset), .in_valid(pop), .angle(pop_data[63:32]),
      .out_valid(sc_vld2), .cos_out(c2), .sin_out(s2)
   );
   gcr_sincos #(.STAGES(CORDIC_STAGES)) u_sc_delta (
      .clock(clock), .reset(reset), .in_valid(pop), .angle(pop_data[31:0]),
      .out_valid(sc_vld3), .cos_out(cd), .sin_out(sd)
   );

   logic               m1_vld_ff, m2_vld_ff, m3_vld_ff, m4_vld_ff;
   logic signed [63:0] p1_ff, p2_ff;
   logic signed [31:0] cd1_ff;
   logic signed [33:0] a_in, b_ff;
   logic signed [65:0] q_ff;
   logic signed [35:0] sum_in;
   logic signed [31:0] c_ff, c4_ff;
   logic [60:0]        sq_ff;

   assign a_in   = 34'(p1_ff >>> 30);
   assign sum_in = 36'(q_ff >>> 30) + 36'(b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         m3_vld_ff <= 1'b0;
         m4_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= sc_vld1;
         m2_vld_ff <= m1_vld_ff;
         m3_vld_ff <= m2_vld_ff;
         m4_vld_ff <= m3_vld_ff;
      end
      p1_ff  <= c1 * c2;
      p2_ff  <= s1 * s2;
      cd1_ff <= cd;
      q_ff   <= a_in * 66'(cd1_ff);
      b_ff   <= 34'(p2_ff >>> 30);
      if (sum_in > 36'(ONE_Q30)) begin
         c_ff <= 32'(ONE_Q30);
      end else if (sum_in < -36'(ONE_Q30)) begin
         c_ff <= 32'(-ONE_Q30);
      end else begin
         c_ff <= 32'(sum_in);
      end
      sq_ff <= 61'(c_ff * c_ff);
      c4_ff <= c_ff;
   end

   logic               sq_vld;
   logic [30:0]        root;
   logic signed [31:0] c_sq;
   logic               ac_vld;
   logic [31:0]        ang;

   gcr_isqrt u_isqrt (
      .clock(clock), .reset(reset), .in_valid(m4_vld_ff),
      .value(61'(61'h1 << 60) - sq_ff), .tag_in(c4_ff),
      .out_valid(sq_vld), .root(root), .tag_out(c_sq)
   );

   gcr_acos #(.STAGES(CORDIC_STAGES)) u_acos (
      .clock(clock), .reset(reset), .in_valid(sq_vld),
      .cos_val(c_sq), .sin_val(root),
      .out_valid(ac_vld), .angle(ang)
   );

   logic        d1_vld_ff, out_vld_ff;
   logic [63:0] prod_ff;
   logic [29:0] dist_in;
   gcr_rsp_type rsp_ff;

   assign dist_in = 30'((prod_ff + 64'h8000_0000) >> 32);

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         d1_vld_ff  <= ac_vld;
         out_vld_ff <= d1_vld_ff;
      end
      prod_ff               <= 64'(ang) * 64'(DIST_SCALE);
      rsp_ff.distance_miles <= dist_in;
      rsp_ff.inside_res     <= (dist_in <= radius_ff);
   end

   assign rsp_valid = out_vld_ff;
   assign rsp       = rsp_ff;

   never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("Queue filled although the back end drains every cycle.");
   dist_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.distance_miles <= 30'd815952420))
      else $error("Distance beyond half the earth circumference.");
   lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (sc_vld1 == sc_vld2) && (sc_vld1 == sc_vld3))
      else $error("Sine and cosine pipelines out of step.");

endmodule
